@@ hw/rtl/sfgm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensitive file name glob matcher package
// Shared sizes, codes, reset values and the link types that join the cells.
// ----------------------------------------------------------------------------
package sfgm_pkg;

    localparam int PatternChars = 8;
    localparam int PatternSlots = 6;
    localparam int PosCells     = PatternChars + 1;
    localparam int PatternBits  = 8 * PatternChars;
    localparam int CountBits    = 3;
    localparam int CfgIdxBits   = 3;

    localparam logic [CfgIdxBits-1:0] CfgIdxCount = 3'd6;

    localparam logic [7:0] StarByte      = 8'h2A;
    localparam logic [7:0] SlashByte     = 8'h2F;
    localparam logic [7:0] BackslashByte = 8'h5C;
    localparam logic [7:0] UpperA        = 8'h41;
    localparam logic [7:0] UpperZ        = 8'h5A;
    localparam logic [7:0] CaseBit       = 8'h20;

    typedef logic [PatternBits-1:0] t_pattern;

    localparam t_pattern PatternReset [PatternSlots] = '{
        64'd182375572782,
        64'd508658265642,
        64'd521392565802,
        64'd469853285930,
        64'd3059181588859679530,
        64'd0
    };
    localparam logic [CountBits-1:0] CountReset = 3'd5;

    // Signals passed from one position cell to the next.
    typedef struct packed {
        logic adv;
        logic carry;
        logic valid;
        logic rs;
    } t_link;

    // Per-byte control common to all cells.
    typedef struct packed {
        logic step;
        logic restart;
        logic fresh;
    } t_cell_ctl;

endpackage

@@ hw/rtl/sfgm_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glob position cell
// Holds the active bit of one pattern position and passes advance, star
// closure, pattern extent and restart closure on to the next position.
// ----------------------------------------------------------------------------
module sfgm_cell (
    input  logic                 i_clk,
    input  sfgm_pkg::t_link      i_link,
    output sfgm_pkg::t_link      o_link,
    input  sfgm_pkg::t_cell_ctl  i_ctl,
    input  logic [7:0]           i_pat_byte,
    input  logic [7:0]           i_path_byte,
    output logic                 o_end
);

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= sfgm_pkg::UpperA && c <= sfgm_pkg::UpperZ) begin
            return c | sfgm_pkg::CaseBit;
        end
        return c;
    endfunction

    logic r_act;
    logic n_act;
    logic cur;
    logic own_valid;
    logic is_star;
    logic is_match;
    logic keep;
    logic raw;

    always_comb begin
        cur       = i_ctl.fresh ? i_link.rs : r_act;
        own_valid = i_link.valid & (i_pat_byte != 8'h00);
        is_star   = (i_pat_byte == sfgm_pkg::StarByte);
        is_match  = (fold_case(i_pat_byte) == fold_case(i_path_byte));
        keep      = cur & own_valid & is_star;
        if (i_ctl.step) begin
            raw = keep | i_link.adv;
        end else if (i_ctl.restart) begin
            raw = i_link.adv;
        end else begin
            raw = cur | i_link.adv;
        end
        n_act = raw | i_link.carry;

        o_link.adv   = i_ctl.step & cur & own_valid & ~is_star & is_match;
        o_link.carry = n_act & own_valid & is_star;
        o_link.valid = own_valid;
        o_link.rs    = i_link.rs & own_valid & is_star;
        o_end        = n_act & i_link.valid & ~own_valid;
    end

    always_ff @(posedge i_clk) begin
        r_act <= n_act;
    end

endmodule

@@ hw/rtl/sfgm_slot.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glob pattern slot
// A row of position cells for one pattern; reports a match at the end of
// the pattern after the current byte.
// ----------------------------------------------------------------------------
module sfgm_slot (
    input  logic                 i_clk,
    input  sfgm_pkg::t_pattern   i_pattern,
    input  sfgm_pkg::t_cell_ctl  i_ctl,
    input  logic [7:0]           i_path_byte,
    output logic                 o_hit
);

    sfgm_pkg::t_link                     w_link [sfgm_pkg::PosCells+1];
    logic [sfgm_pkg::PosCells-1:0]       w_end;

    assign w_link[0].adv   = i_ctl.restart;
    assign w_link[0].carry = 1'b0;
    assign w_link[0].valid = 1'b1;
    assign w_link[0].rs    = 1'b1;

    for (genvar g = 0; g < sfgm_pkg::PosCells; g++) begin : g_cell
        logic [7:0] w_pat_byte;
        if (g < sfgm_pkg::PatternChars) begin : g_byte
            assign w_pat_byte = i_pattern[8*g +: 8];
        end else begin : g_tail
            assign w_pat_byte = 8'h00;
        end
        sfgm_cell u_cell (
            .i_clk       (i_clk),
            .i_link      (w_link[g]),
            .o_link      (w_link[g+1]),
            .i_ctl       (i_ctl),
            .i_pat_byte  (w_pat_byte),
            .i_path_byte (i_path_byte),
            .o_end       (w_end[g])
        );
    end

    assign o_hit = |w_end;

endmodule

@@ hw/rtl/sensitive_filename_glob_matcher_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensitive file name glob matcher
// The result of an item with tlast is registered and valid in the cycle after
// it is accepted. One path byte per cycle unless the output stalls; the star
// closure chain runs through the nine position cells of each slot.
// Reset loads the default patterns and count and restarts every slot.
// ----------------------------------------------------------------------------
module sensitive_filename_glob_matcher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,  // path_byte
    input  logic        i_s_tuser,  // present
    input  logic        i_s_tlast,  // last
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,  // sensitive, zero fill
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    sfgm_pkg::t_pattern                 r_pattern [sfgm_pkg::PatternSlots];
    logic [sfgm_pkg::CountBits-1:0]     r_count;
    logic                               r_fresh;
    logic                               n_fresh;
    logic                               r_ovalid;
    logic                               r_osens;
    logic                               in_acc;
    logic                               is_sep;
    logic                               cfg_hit;
    logic                               any_hit;
    sfgm_pkg::t_cell_ctl                w_ctl;
    logic [sfgm_pkg::PatternSlots-1:0]  w_hit;

    assign o_s_tready = ~r_ovalid | i_m_tready;
    assign in_acc     = i_s_tvalid & o_s_tready;
    assign is_sep     = (i_s_tdata == sfgm_pkg::SlashByte) ||
                        (i_s_tdata == sfgm_pkg::BackslashByte);
    assign cfg_hit    = i_cfg_we & (i_cfg_index <= sfgm_pkg::CfgIdxCount);

    assign w_ctl.step    = in_acc & i_s_tuser & ~is_sep;
    assign w_ctl.restart = in_acc & i_s_tuser & is_sep;
    assign w_ctl.fresh   = r_fresh;

    for (genvar s = 0; s < sfgm_pkg::PatternSlots; s++) begin : g_slot
        sfgm_slot u_slot (
            .i_clk       (i_clk),
            .i_pattern   (r_pattern[s]),
            .i_ctl       (w_ctl),
            .i_path_byte (i_s_tdata),
            .o_hit       (w_hit[s])
        );
    end

    always_comb begin
        any_hit = 1'b0;
        for (int s = 0; s < sfgm_pkg::PatternSlots; s++) begin
            if (w_hit[s] && (r_count > sfgm_pkg::CountBits'(s))) begin
                any_hit = 1'b1;
            end
        end
        if (cfg_hit) begin
            n_fresh = 1'b1;
        end else if (in_acc) begin
            n_fresh = i_s_tlast;
        end else begin
            n_fresh = r_fresh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < sfgm_pkg::PatternSlots; s++) begin
                r_pattern[s] <= sfgm_pkg::PatternReset[s];
            end
            r_count <= sfgm_pkg::CountReset;
        end else if (cfg_hit) begin
            if (i_cfg_index == sfgm_pkg::CfgIdxCount) begin
                r_count <= i_cfg_data[sfgm_pkg::CountBits-1:0];
            end else begin
                r_pattern[i_cfg_index] <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh  <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            r_fresh <= n_fresh;
            if (in_acc && i_s_tlast) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_s_tlast) begin
            r_osens <= any_hit;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {7'b0000000, r_osens};

    a_result_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(in_acc && i_s_tlast))
        else $error("result without a last item");

    a_fresh_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_s_tlast) |=> r_fresh)
        else $error("slots not restarted after last item");

    a_fresh_after_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_index <= sfgm_pkg::CfgIdxCount)) |=> r_fresh)
        else $error("slots not restarted after configuration write");

endmodule

@@ sim/sensitive_filename_glob_matcher_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensitive file name glob matcher testbench
// Streams relative paths into the matcher one byte per item and keeps a
// private copy of the pattern registers and of the position vectors of every
// slot. Each verdict the block returns is compared with the one worked out
// here. A short table of paths and register writes runs first. Random phases
// follow, each one sending paths built mostly from the live patterns, then
// writing registers while the block is idle. Both sides stall at random.
// ----------------------------------------------------------------------------
module sensitive_filename_glob_matcher_top_tb;

    localparam int RandomItems = 1350;
    localparam int DrainCycles = 4;
    localparam int StallLimit  = 1000;
    localparam int ReportLimit = 10;

    localparam logic [sfgm_pkg::CfgIdxBits-1:0] CfgIdxUnused = 3'd7;
    localparam logic [7:0] DotByte = 8'h2E;
    localparam logic [7:0] LowerA  = 8'h61;

    typedef enum logic {RowByte, RowWrite} t_row_kind;

    typedef struct {
        t_row_kind                       kind;
        logic [7:0]                      path_byte;
        logic                            present;
        logic                            last;
        int                              stated;
        logic [sfgm_pkg::CfgIdxBits-1:0] index;
        logic [63:0]                     value;
    } t_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata   = 8'h00;
    logic        i_s_tuser   = 1'b0;
    logic        i_s_tlast   = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [7:0]  o_m_tdata;
    logic        i_cfg_we    = 1'b0;
    logic [2:0]  i_cfg_index = 3'd0;
    logic [63:0] i_cfg_data  = 64'd0;

    sfgm_pkg::t_pattern             slot_pattern [sfgm_pkg::PatternSlots];
    logic [sfgm_pkg::CountBits-1:0] slots_in_use;
    logic [sfgm_pkg::PosCells-1:0]  slot_pos [sfgm_pkg::PatternSlots];
    logic                           pending_verdicts [$];
    t_row                           directed [$];

    int stated_result = -1;
    bit quiet         = 1'b0;
    int sink_wait     = 0;
    int results_seen  = 0;
    int results_noted = 0;
    int mismatches    = 0;
    int idle_cycles   = 0;
    int items_sent    = 0;

    sensitive_filename_glob_matcher_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] fold(input logic [7:0] c);
        return (c >= sfgm_pkg::UpperA && c <= sfgm_pkg::UpperZ) ?
               (c | sfgm_pkg::CaseBit) : c;
    endfunction

    function automatic int glob_len(input sfgm_pkg::t_pattern p);
        int n;
        n = 0;
        while (n < sfgm_pkg::PatternChars && p[8*n +: 8] != 8'h00) n++;
        return n;
    endfunction

    function automatic logic [sfgm_pkg::PosCells-1:0] close_stars(
        input sfgm_pkg::t_pattern p,
        input logic [sfgm_pkg::PosCells-1:0] v);
        int n;
        int i;
        logic [sfgm_pkg::PosCells-1:0] r;
        n = glob_len(p);
        r = v;
        for (i = 0; i < n; i++) begin
            if (r[i] && p[8*i +: 8] == sfgm_pkg::StarByte) r[i+1] = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [sfgm_pkg::PosCells-1:0] consume(
        input sfgm_pkg::t_pattern p,
        input logic [sfgm_pkg::PosCells-1:0] v,
        input logic [7:0] c);
        int n;
        int i;
        logic [7:0] pc;
        logic [sfgm_pkg::PosCells-1:0] r;
        n = glob_len(p);
        r = '0;
        for (i = 0; i < n; i++) begin
            if (v[i]) begin
                pc = p[8*i +: 8];
                if (pc == sfgm_pkg::StarByte) begin
                    r[i] = 1'b1;
                end else if (fold(pc) == fold(c)) begin
                    r[i+1] = 1'b1;
                end
            end
        end
        return close_stars(p, r);
    endfunction

    function automatic void restart_slots();
        int s;
        for (s = 0; s < sfgm_pkg::PatternSlots; s++) begin
            slot_pos[s] = close_stars(slot_pattern[s], sfgm_pkg::PosCells'(1));
        end
    endfunction

    function automatic logic base_name_hit();
        int s;
        int enabled;
        logic hit;
        enabled = (slots_in_use > sfgm_pkg::PatternSlots) ? sfgm_pkg::PatternSlots :
                  int'(slots_in_use);
        hit = 1'b0;
        for (s = 0; s < enabled; s++) begin
            if (slot_pos[s][glob_len(slot_pattern[s])]) hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic sfgm_pkg::t_pattern random_pattern();
        sfgm_pkg::t_pattern p;
        int k;
        int len;
        logic [7:0] c;
        p = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: p = '0;
            1: p = '1;
            2: ;
            default: begin
                len = $urandom_range(0, sfgm_pkg::PatternChars);
                for (k = 0; k < len; k++) begin
                    case ($urandom_range(0, 5))
                        0: c = sfgm_pkg::StarByte;
                        1: c = DotByte;
                        default: begin
                            c = LowerA + 8'($urandom_range(0, 25));
                            if ($urandom_range(0, 1) == 1) c = c ^ sfgm_pkg::CaseBit;
                        end
                    endcase
                    p[8*k +: 8] = c;
                end
                if (len < sfgm_pkg::PatternChars) p[8*len +: 8] = 8'h00;
            end
        endcase
        return p;
    endfunction

    // Predicts the verdict of every accepted last item and checks every result.
    always @(posedge i_clk) begin
        logic verdict;
        if (!i_rst_n) begin
            slot_pattern = sfgm_pkg::PatternReset;
            slots_in_use = sfgm_pkg::CountReset;
            restart_slots();
            pending_verdicts.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == sfgm_pkg::CfgIdxCount) begin
                    slots_in_use = i_cfg_data[sfgm_pkg::CountBits-1:0];
                    restart_slots();
                end else if (i_cfg_index < sfgm_pkg::CfgIdxCount) begin
                    slot_pattern[i_cfg_index] = i_cfg_data;
                    restart_slots();
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                if (i_s_tuser) begin
                    if (i_s_tdata == sfgm_pkg::SlashByte ||
                        i_s_tdata == sfgm_pkg::BackslashByte) begin
                        restart_slots();
                    end else begin
                        for (int s = 0; s < sfgm_pkg::PatternSlots; s++) begin
                            slot_pos[s] = consume(slot_pattern[s], slot_pos[s], i_s_tdata);
                        end
                    end
                end
                if (i_s_tlast) begin
                    verdict = (stated_result < 0) ? base_name_hit() : stated_result[0];
                    pending_verdicts.push_back(verdict);
                    restart_slots();
                end
            end
            if (o_m_tvalid && i_m_tready) begin
                results_seen++;
                if (pending_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= ReportLimit) begin
                        $display("unexpected result: tdata=%02h", o_m_tdata);
                    end
                end else begin
                    verdict = pending_verdicts.pop_front();
                    if (o_m_tdata !== {7'd0, verdict}) begin
                        mismatches++;
                        if (mismatches <= ReportLimit) begin
                            $display("mismatch: expected sensitive=%0b, got tdata=%02h",
                                     verdict, o_m_tdata);
                        end
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (results_seen != results_noted) begin
            results_noted = results_seen;
            sink_wait = quiet ? 0 : $urandom_range(0, 3);
        end
        if (sink_wait > 0) begin
            sink_wait--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
            || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= StallLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic pres, input logic lst,
                             input int stated);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid    <= 1'b1;
        i_s_tdata     <= b;
        i_s_tuser     <= pres;
        i_s_tlast     <= lst;
        stated_result <= stated;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [sfgm_pkg::CfgIdxBits-1:0] index,
                             input logic [63:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Waits until every verdict is back and the block has had time to go idle.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    task automatic add_byte(input logic [7:0] b, input logic pres, input logic lst,
                            input int stated);
        t_row row;
        row = '{RowByte, b, pres, lst, stated, '0, '0};
        directed.push_back(row);
    endtask

    task automatic add_name(input string name, input bit finish, input int stated);
        int k;
        for (k = 0; k < name.len(); k++) begin
            if (finish && k == name.len() - 1) begin
                add_byte(name[k], 1'b1, 1'b1, stated);
            end else begin
                add_byte(name[k], 1'b1, 1'b0, -1);
            end
        end
    endtask

    task automatic add_write(input logic [sfgm_pkg::CfgIdxBits-1:0] index,
                             input logic [63:0] value);
        t_row row;
        row = '{RowWrite, 8'h00, 1'b0, 1'b0, -1, index, value};
        directed.push_back(row);
    endtask

    // Builds a path whose base name mostly follows one of the live patterns.
    task automatic send_path(input bit finish);
        logic [7:0] name [$];
        sfgm_pkg::t_pattern p;
        int k;
        int len;
        int mode;
        bit tail_absent;
        logic [7:0] c;
        repeat ($urandom_range(0, 2)) begin
            repeat ($urandom_range(0, 3)) name.push_back(LowerA + 8'($urandom_range(0, 25)));
            name.push_back(($urandom_range(0, 1) == 1) ? sfgm_pkg::SlashByte :
                           sfgm_pkg::BackslashByte);
        end
        mode = $urandom_range(0, 9);
        if (mode < 2) begin
            repeat ($urandom_range(0, 6)) name.push_back(8'($urandom_range(0, 255)));
        end else begin
            p = slot_pattern[$urandom_range(0, sfgm_pkg::PatternSlots - 1)];
            len = glob_len(p);
            for (k = 0; k < len; k++) begin
                c = p[8*k +: 8];
                if (c == sfgm_pkg::StarByte) begin
                    repeat ($urandom_range(0, 2)) begin
                        name.push_back(sfgm_pkg::UpperA + 8'($urandom_range(0, 57)));
                    end
                end else begin
                    if (fold(c) >= LowerA && fold(c) <= (LowerA + 8'd25)
                        && $urandom_range(0, 1) == 1) begin
                        c = c ^ sfgm_pkg::CaseBit;
                    end
                    if (mode == 2 && $urandom_range(0, len) == 0) c = 8'($urandom_range(0, 255));
                    name.push_back(c);
                end
            end
        end
        tail_absent = ($urandom_range(0, 7) == 0) || (name.size() == 0);
        for (k = 0; k < name.size(); k++) begin
            if ($urandom_range(0, 15) == 0) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, -1);
            send_byte(name[k], 1'b1, finish && !tail_absent && k == name.size() - 1, -1);
        end
        if (finish && tail_absent) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1, -1);
    endtask

    initial begin
        int r;
        int s;
        int start;
        logic [sfgm_pkg::CfgIdxBits-1:0] index;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default patterns straight after reset.
        add_byte(8'h00, 1'b0, 1'b1, 0);
        add_name(".ENV", 1'b1, 1);
        add_name("a\\", 1'b1, 0);
        add_byte(8'h00, 1'b1, 1'b0, -1);
        add_byte(8'hFF, 1'b1, 1'b1, -1);
        add_name(".e", 1'b0, -1);
        add_byte(8'hA5, 1'b0, 1'b0, -1);
        add_name("nv", 1'b1, 1);
        // All slots enabled, the last one empty.
        add_write(sfgm_pkg::CfgIdxCount, 64'd7);
        add_write(sfgm_pkg::CfgIdxBits'(5), 64'd0);
        add_byte(8'h00, 1'b0, 1'b1, 1);
        add_write(sfgm_pkg::CfgIdxBits'(5), 64'h0000_0000_0000_2A61);
        add_byte(8'h41, 1'b1, 1'b0, -1);
        add_byte(8'h00, 1'b1, 1'b1, 1);
        add_write(CfgIdxUnused, '1);
        add_name(".KEY", 1'b1, -1);
        // A register write abandons the path in progress.
        add_name(".en", 1'b0, -1);
        add_write(sfgm_pkg::CfgIdxCount, 64'd5);
        add_name("v", 1'b1, -1);
        add_write(sfgm_pkg::CfgIdxCount, 64'd0);
        add_name("x", 1'b1, 0);

        for (r = 0; r < directed.size(); r++) begin
            if (directed[r].kind == RowWrite) begin
                settle();
                write_reg(directed[r].index, directed[r].value);
            end else begin
                send_byte(directed[r].path_byte, directed[r].present, directed[r].last,
                          directed[r].stated);
            end
        end

        settle();
        for (s = 0; s < sfgm_pkg::PatternSlots; s++) begin
            write_reg(sfgm_pkg::CfgIdxBits'(s), random_pattern());
        end
        write_reg(sfgm_pkg::CfgIdxCount, 64'(sfgm_pkg::PatternSlots));

        start = items_sent;
        while (items_sent - start < RandomItems) begin
            quiet = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(4, 20)) send_path(1'b1);
            if ($urandom_range(0, 4) == 0) send_path(1'b0);
            settle();
            repeat ($urandom_range(1, 3)) begin
                index = sfgm_pkg::CfgIdxBits'($urandom_range(0, 7));
                if (index == sfgm_pkg::CfgIdxCount) begin
                    write_reg(index, {$urandom, $urandom});
                end else begin
                    write_reg(index, random_pattern());
                end
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
